>>> rtl/core/framed_packet_parser_xor_macros.svh
// Assertion macros shared by the frame parser RTL.
// Included by the top level; no other dependencies.
`ifndef FRAMED_PACKET_PARSER_XOR_MACROS_SVH
`define FRAMED_PACKET_PARSER_XOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

>>> rtl/core/fpp_pkg.sv
// Shared types and constants for the framed packet parser.
// Used by the controller, the datapath and the top level.
package fpp_pkg;

  localparam int MAX_LEN_DEFAULT = 32;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_ENABLE = 1'd1;

  localparam logic [7:0] START_MARKER_RESET   = 8'd126;
  localparam logic       DELIVER_ENABLE_RESET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_type;
    logic load_len;
    logic store_byte;
    logic clear_ptr;
    logic burst;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic sof_match;
    logic len_bad;
    logic len_zero;
    logic fill_done;
    logic xor_match;
    logic burst_done;
  } dp_status_t;

endpackage

>>> rtl/core/fpp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fpp_ctrl.sv
// Frame parser controller: one-hot state machine that sequences the datapath.
// Depends on fpp_pkg for the command and status structs.
module fpp_ctrl
  import fpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_WAIT    = 6'b000001,
    ST_TYPE    = 6'b000010,
    ST_LEN     = 6'b000100,
    ST_PAYLOAD = 6'b001000,
    ST_CHECK   = 6'b010000,
    ST_BURST   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_ready = (state != ST_BURST);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_WAIT: begin
        if (in_fire && status.sof_match) begin
          state_next = ST_TYPE;
        end
      end
      ST_TYPE: begin
        if (in_fire) begin
          cmd.load_type = 1'b1;
          state_next    = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          if (status.len_bad) begin
            state_next = ST_WAIT;
          end else begin
            cmd.load_len = 1'b1;
            state_next   = status.len_zero ? ST_CHECK : ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_fire) begin
          cmd.store_byte = 1'b1;
          if (status.fill_done) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          cmd.clear_ptr = 1'b1;
          state_next    = status.xor_match ? ST_BURST : ST_WAIT;
        end
      end
      ST_BURST: begin
        cmd.burst = 1'b1;
        if (status.burst_done) begin
          state_next = ST_WAIT;
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/fpp_dpath.sv
// Frame parser datapath: configuration, header capture, checksum, payload store
// and the two-stage result pipeline. Depends on fpp_pkg and fpp_ram.
module fpp_dpath
  import fpp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            rx_byte,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            frame_type,
  output logic [5:0]            frame_length,
  output logic [7:0]            data_byte,
  output logic [4:0]            byte_position,
  output logic                  has_data,
  output logic                  last
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [7:0]    start_marker;
  logic          deliver_enable;

  logic [7:0]    held_type;
  logic [LW-1:0] held_length;
  logic [LW-1:0] fill_index;
  logic [7:0]    running_xor;
  logic [LW-1:0] rd_ptr;

  logic          issue;
  logic          issue_last;
  logic          s1_move;
  logic [7:0]    rdata;

  // Stage one: the item whose payload byte sits in the RAM read register.
  logic          s1_valid;
  logic [7:0]    s1_type;
  logic [LW-1:0] s1_len;
  logic [AW-1:0] s1_pos;
  logic          s1_has;
  logic          s1_last;

  // Output register.
  logic [7:0]    out_type;
  logic [LW-1:0] out_len;
  logic [7:0]    out_data;
  logic [AW-1:0] out_pos;
  logic          out_has;
  logic          out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker   <= START_MARKER_RESET;
      deliver_enable <= DELIVER_ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_MARKER:   start_marker   <= cfg_data[7:0];
        CFG_DELIVER_ENABLE: deliver_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign status.sof_match = (rx_byte == start_marker);
  assign status.len_bad   = (rx_byte > 8'(MAX_LEN));
  assign status.len_zero  = (rx_byte == 8'd0);
  assign status.fill_done = ({1'b0, fill_index} + (LW+1)'(1)) >= {1'b0, held_length};
  assign status.xor_match = (rx_byte == running_xor) && deliver_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type   <= '0;
      held_length <= '0;
      fill_index  <= '0;
      running_xor <= '0;
    end else begin
      if (cmd.load_type) begin
        held_type   <= rx_byte;
        running_xor <= rx_byte;
      end
      if (cmd.load_len) begin
        held_length <= LW'(rx_byte);
        running_xor <= running_xor ^ rx_byte;
        fill_index  <= '0;
      end
      if (cmd.store_byte) begin
        running_xor <= running_xor ^ rx_byte;
        fill_index  <= fill_index + LW'(1);
      end
    end
  end

  // A new read is issued only when stage one is free or drains this cycle.
  assign s1_move    = s1_valid && (!out_valid || out_ready);
  assign issue      = cmd.burst && (!s1_valid || s1_move);
  assign issue_last = (held_length == '0) ||
                      (({1'b0, rd_ptr} + (LW+1)'(1)) == {1'b0, held_length});
  assign status.burst_done = issue && issue_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else if (cmd.clear_ptr) begin
      rd_ptr <= '0;
    end else if (issue) begin
      rd_ptr <= rd_ptr + LW'(1);
    end
  end

  fpp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_byte),
    .waddr(fill_index[AW-1:0]),
    .wdata(rx_byte),
    .re   (issue),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Header fields travel with each item, since a new frame may start
  // before the last items of this one have been taken.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_type <= held_type;
      s1_len  <= held_length;
      s1_pos  <= rd_ptr[AW-1:0];
      s1_has  <= (held_length != '0);
      s1_last <= issue_last;
    end
    if (s1_move) begin
      out_type <= s1_type;
      out_len  <= s1_len;
      out_data <= s1_has ? rdata : 8'd0;
      out_pos  <= s1_pos;
      out_has  <= s1_has;
      out_last <= s1_last;
    end
  end

  assign frame_type    = out_type;
  assign frame_length  = 6'(out_len);
  assign data_byte     = out_data;
  assign byte_position = 5'(out_pos);
  assign has_data      = out_has;
  assign last          = out_last;

endmodule

>>> rtl/core/framed_packet_parser_xor.sv
// Top level of the framed packet parser: controller, datapath and checks.
// Depends on fpp_pkg, fpp_ctrl, fpp_dpath, fpp_ram and the macros header.

// Byte-serial parser for frames of start byte, type, length, payload and an
// XOR checksum over type, length and payload. While a frame is being parsed
// one byte is accepted every cycle. When a frame passes its checksum and
// delivery is enabled, input is held off while the payload is read back from
// the payload RAM, one item issued per cycle unless the output side stalls,
// max(length, 1) items in all. The RAM read register and the output register
// form a two-item pipeline, so the next frame's bytes are accepted while the
// last items of the burst still wait. An empty frame gives one item with
// has_data low. Bad checksums, oversized lengths and frames with delivery
// disabled give no items.
`include "framed_packet_parser_xor_macros.svh"

module framed_packet_parser_xor
  import fpp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            frame_type,
  output logic [5:0]            frame_length,
  output logic [7:0]            data_byte,
  output logic [4:0]            byte_position,
  output logic                  has_data,
  output logic                  last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fpp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  fpp_dpath #(
    .MAX_LEN(MAX_LEN)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_type   (frame_type),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .byte_position(byte_position),
    .has_data     (has_data),
    .last         (last)
  );

  // Once the final item of a burst is issued, input is open again.
  `FPP_ASSERT_NEXT(a_burst_releases_input, clk, rst, status.burst_done, in_ready)

  // An item without data only comes from an empty frame and closes it.
  `FPP_ASSERT_IMPLY(a_empty_item, clk, rst, out_valid && !has_data, frame_length == 6'd0 && last && data_byte == 8'd0)

  // The final data item of a burst sits at the end of the frame.
  `FPP_ASSERT_IMPLY(a_last_position, clk, rst, out_valid && has_data && last, byte_position == 5'(frame_length - 6'd1))

endmodule
